/* sv/ucbm_pkg.sv */
// ---------------------------------------------------------------------------
// ucbm_pkg: shared types and constants
// State codes, controller/datapath command and status bundles, field widths.
// ---------------------------------------------------------------------------
`default_nettype none

package ucbm_pkg;

  localparam int unsigned MaxNodesDef   = 64;
  localparam int unsigned MaxEdgesDef   = 64;
  localparam int unsigned WeightBitsDef = 16;

  localparam int unsigned IdW          = 6;
  localparam int unsigned PortWeightW  = 16;
  localparam int unsigned TotalW       = 22;
  localparam int unsigned NodeCountW   = 7;
  localparam int unsigned NodeCountRst = 64;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // register word index on the config port
  localparam logic RegNodeCount = 1'b0;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_LOAD,
    S_SEL_INIT,
    S_SEL_RUN,
    S_SEL_LAST,
    S_CHECK,
    S_FIND_RD,
    S_FIND_CHK,
    S_JOIN,
    S_EMIT_PREP,
    S_EMIT_EMPTY,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic run_clear;
    logic load;
    logic sel_init;
    logic scan_rd;
    logic mark_visited;
    logic pass_done;
    logic find_u;
    logic find_rd;
    logic find_step;
    logic find_to_v;
    logic join_roots;
    logic emit_prep;
    logic emit;
    logic emit_empty;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_last;
    logic out_of_range;
    logic find_hit;
    logic pass_last_edges;
    logic pass_last_removed;
    logic none_removed;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* sv/ucbm_ram.sv */
// ---------------------------------------------------------------------------
// ucbm_ram: generic memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ucbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/ucbm_ctrl.sv */
// ---------------------------------------------------------------------------
// ucbm_ctrl: sequencer
// Steps through load, selection scans, root finds, joins and result output.
// ---------------------------------------------------------------------------
`default_nettype none

module ucbm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_last_i,
  output logic               in_ready_o,
  input  wire ucbm_pkg::sts_t sts_i,
  output ucbm_pkg::cmd_t     cmd_o
);
  import ucbm_pkg::*;

  state_e state_q, state_d;
  logic   phase_q;   // 0: forest build, 1: result output
  logic   which_q;   // 0: finding root of first end, 1: second end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:      if (sts_i.clr_done) state_d = S_LOAD;
      S_LOAD:       if (in_valid_i && in_last_i) state_d = S_SEL_INIT;
      S_SEL_INIT:   state_d = S_SEL_RUN;
      S_SEL_RUN:    if (sts_i.scan_last) state_d = S_SEL_LAST;
      S_SEL_LAST:   state_d = phase_q ? S_EMIT : S_CHECK;
      S_CHECK: begin
        if (!sts_i.out_of_range) state_d = S_FIND_RD;
        else if (sts_i.pass_last_edges) state_d = S_EMIT_PREP;
        else state_d = S_SEL_INIT;
      end
      S_FIND_RD:    state_d = S_FIND_CHK;
      S_FIND_CHK: begin
        if (!sts_i.find_hit || !which_q) state_d = S_FIND_RD;
        else state_d = S_JOIN;
      end
      S_JOIN:       state_d = sts_i.pass_last_edges ? S_EMIT_PREP : S_SEL_INIT;
      S_EMIT_PREP:  state_d = sts_i.none_removed ? S_EMIT_EMPTY : S_SEL_INIT;
      S_EMIT_EMPTY: if (sts_i.out_free) state_d = S_CLEAR;
      S_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.pass_last_removed ? S_CLEAR : S_SEL_INIT;
      end
      default:      state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step  = 1'b1;
        cmd_o.run_clear = 1'b1;
      end
      S_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SEL_INIT: cmd_o.sel_init = 1'b1;
      S_SEL_RUN:  cmd_o.scan_rd = 1'b1;
      S_SEL_LAST: ;
      S_CHECK: begin
        cmd_o.mark_visited = 1'b1;
        if (sts_i.out_of_range) cmd_o.pass_done = 1'b1;
        else cmd_o.find_u = 1'b1;
      end
      S_FIND_RD: cmd_o.find_rd = 1'b1;
      S_FIND_CHK: begin
        if (!sts_i.find_hit) cmd_o.find_step = 1'b1;
        else if (!which_q) cmd_o.find_to_v = 1'b1;
      end
      S_JOIN: begin
        cmd_o.join_roots = 1'b1;
        cmd_o.pass_done  = 1'b1;
      end
      S_EMIT_PREP:  cmd_o.emit_prep = 1'b1;
      S_EMIT_EMPTY: cmd_o.emit_empty = sts_i.out_free;
      S_EMIT: begin
        cmd_o.emit         = sts_i.out_free;
        cmd_o.mark_visited = sts_i.out_free;
        cmd_o.pass_done    = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      phase_q <= 1'b0;
      which_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.run_clear) phase_q <= 1'b0;
      else if (cmd_o.emit_prep) phase_q <= 1'b1;
      if (cmd_o.find_u) which_q <= 1'b0;
      else if (cmd_o.find_to_v) which_q <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* sv/ucbm_dp.sv */
// ---------------------------------------------------------------------------
// ucbm_dp: datapath
// Edge store, parent store, selection scan, saturating total, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module ucbm_dp #(
  parameter int unsigned MAX_NODES   = ucbm_pkg::MaxNodesDef,
  parameter int unsigned MAX_EDGES   = ucbm_pkg::MaxEdgesDef,
  parameter int unsigned WEIGHT_BITS = ucbm_pkg::WeightBitsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire ucbm_pkg::cmd_t                      cmd_i,
  output ucbm_pkg::sts_t                           sts_o,
  input  wire logic [ucbm_pkg::NodeCountW-1:0]     node_count_i,
  input  wire logic [ucbm_pkg::IdW-1:0]            in_from_i,
  input  wire logic [ucbm_pkg::IdW-1:0]            in_to_i,
  input  wire logic [ucbm_pkg::PortWeightW-1:0]    in_weight_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic      [ucbm_pkg::IdW-1:0]            out_from_o,
  output logic      [ucbm_pkg::IdW-1:0]            out_to_o,
  output logic      [ucbm_pkg::PortWeightW-1:0]    out_weight_o,
  output logic      [ucbm_pkg::TotalW-1:0]         out_total_o,
  output logic                                     out_flag_o,
  output logic                                     out_last_o
);
  import ucbm_pkg::*;

  localparam int unsigned IdxW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned NodeW = $clog2(MAX_NODES);
  localparam int unsigned LimW  = ($clog2(MAX_NODES + 1) > NodeCountW) ?
                                  $clog2(MAX_NODES + 1) : NodeCountW;
  localparam int unsigned EdgeW = 2 * IdW + WEIGHT_BITS;
  localparam int unsigned ExtW  = (WEIGHT_BITS > PortWeightW) ? WEIGHT_BITS : PortWeightW;
  localparam int unsigned SumW  = ((WEIGHT_BITS > TotalW) ? WEIGHT_BITS : TotalW) + 1;
  localparam logic signed [SumW-1:0] TotMax = SumW'((2 ** (TotalW - 1)) - 1);
  localparam logic signed [SumW-1:0] TotMin = SumW'(-(2 ** (TotalW - 1)));

  // edge store and scan
  logic [CntW-1:0]          edge_cnt_q;
  logic [IdxW-1:0]          scan_idx_q;
  logic [IdxW-1:0]          rd_idx_q;
  logic                     rd_pend_q;
  logic [EdgeW-1:0]         edge_wdata;
  logic [EdgeW-1:0]         edge_rdata;
  logic                     edge_we;
  logic [IdW-1:0]           rd_from;
  logic [IdW-1:0]           rd_to;
  logic signed [WEIGHT_BITS-1:0] rd_w;
  logic [MAX_EDGES-1:0]     visited_q;
  logic [MAX_EDGES-1:0]     removed_q;
  logic [CntW-1:0]          removed_cnt_q;
  logic [CntW-1:0]          pass_cnt_q;

  // best candidate of the current scan
  logic                     best_valid_q;
  logic [IdxW-1:0]          best_idx_q;
  logic [IdW-1:0]           best_from_q;
  logic [IdW-1:0]           best_to_q;
  logic signed [WEIGHT_BITS-1:0] best_w_q;
  logic                     take_cand;

  // union-find
  logic [NodeW-1:0]         clr_idx_q;
  logic [NodeW-1:0]         x_q;
  logic [NodeW-1:0]         ru_q;
  logic [NodeW-1:0]         par_rdata;
  logic                     par_we;
  logic [NodeW-1:0]         par_waddr;
  logic [NodeW-1:0]         par_wdata;
  logic [LimW-1:0]          lim;

  // total
  logic signed [TotalW-1:0] total_q;
  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   sum_sat;
  logic signed [ExtW-1:0]   best_w_ext;

  // result register
  logic                     out_valid_q;

  assign edge_we    = cmd_i.load && (edge_cnt_q < CntW'(MAX_EDGES));
  assign edge_wdata = {WEIGHT_BITS'(in_weight_i), in_to_i, in_from_i};

  ucbm_ram #(
    .Width (EdgeW),
    .Depth (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_cnt_q[IdxW-1:0]),
    .wdata_i (edge_wdata),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (scan_idx_q),
    .rdata_o (edge_rdata)
  );

  assign rd_from = edge_rdata[IdW-1:0];
  assign rd_to   = edge_rdata[2*IdW-1:IdW];
  assign rd_w    = edge_rdata[EdgeW-1:2*IdW];

  // ascending scan: on equal weight the later edge wins
  assign take_cand = rd_pend_q && !visited_q[rd_idx_q] &&
                     (!best_valid_q || (rd_w >= best_w_q));

  // only connectivity matters for which edges close a cycle, so a plain
  // root-to-root link is enough
  assign par_we    = cmd_i.clr_step || (cmd_i.join_roots && (ru_q != x_q));
  assign par_waddr = cmd_i.clr_step ? clr_idx_q : ru_q;
  assign par_wdata = cmd_i.clr_step ? clr_idx_q : x_q;

  ucbm_ram #(
    .Width (NodeW),
    .Depth (MAX_NODES)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .re_i    (cmd_i.find_rd),
    .raddr_i (x_q),
    .rdata_o (par_rdata)
  );

  assign lim = (LimW'(node_count_i) < LimW'(MAX_NODES)) ? LimW'(node_count_i)
                                                        : LimW'(MAX_NODES);

  assign sum = SumW'(total_q) + SumW'(best_w_q);
  always_comb begin
    if (sum > TotMax) sum_sat = TotMax;
    else if (sum < TotMin) sum_sat = TotMin;
    else sum_sat = sum;
  end

  assign best_w_ext = ExtW'(best_w_q);

  always_comb begin
    sts_o                   = '0;
    sts_o.clr_done          = (clr_idx_q == NodeW'(MAX_NODES - 1));
    sts_o.scan_last         = ((CntW'(scan_idx_q) + CntW'(1)) == edge_cnt_q);
    sts_o.out_of_range      = (LimW'(best_from_q) >= lim) || (LimW'(best_to_q) >= lim);
    sts_o.find_hit          = (par_rdata == x_q);
    sts_o.pass_last_edges   = ((pass_cnt_q + CntW'(1)) == edge_cnt_q);
    sts_o.pass_last_removed = ((pass_cnt_q + CntW'(1)) == removed_cnt_q);
    sts_o.none_removed      = (removed_cnt_q == '0);
    sts_o.out_free          = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_cnt_q    <= '0;
      scan_idx_q    <= '0;
      rd_pend_q     <= 1'b0;
      visited_q     <= '0;
      removed_q     <= '0;
      removed_cnt_q <= '0;
      pass_cnt_q    <= '0;
      best_valid_q  <= 1'b0;
      clr_idx_q     <= '0;
      total_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.scan_rd;
      if (cmd_i.clr_step) begin
        clr_idx_q <= sts_o.clr_done ? '0 : clr_idx_q + NodeW'(1);
      end
      if (cmd_i.run_clear) begin
        edge_cnt_q    <= '0;
        visited_q     <= '0;
        removed_q     <= '0;
        removed_cnt_q <= '0;
        pass_cnt_q    <= '0;
        total_q       <= '0;
      end
      if (edge_we) edge_cnt_q <= edge_cnt_q + CntW'(1);
      if (cmd_i.sel_init) begin
        scan_idx_q   <= '0;
        best_valid_q <= 1'b0;
      end
      if (cmd_i.scan_rd) scan_idx_q <= scan_idx_q + IdxW'(1);
      if (take_cand) best_valid_q <= 1'b1;
      if (cmd_i.mark_visited) visited_q[best_idx_q] <= 1'b1;
      if (cmd_i.pass_done) pass_cnt_q <= pass_cnt_q + CntW'(1);
      if (cmd_i.join_roots && (ru_q == x_q)) begin
        removed_q[best_idx_q] <= 1'b1;
        removed_cnt_q         <= removed_cnt_q + CntW'(1);
        total_q               <= TotalW'(sum_sat);
      end
      if (cmd_i.emit_prep) begin
        visited_q  <= ~removed_q;
        pass_cnt_q <= '0;
      end
      if (cmd_i.emit || cmd_i.emit_empty) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_idx_q;
    if (take_cand) begin
      best_idx_q  <= rd_idx_q;
      best_from_q <= rd_from;
      best_to_q   <= rd_to;
      best_w_q    <= rd_w;
    end
    if (cmd_i.find_u) x_q <= NodeW'(best_from_q);
    if (cmd_i.find_step) x_q <= par_rdata;
    if (cmd_i.find_to_v) begin
      ru_q <= x_q;
      x_q  <= NodeW'(best_to_q);
    end
    if (cmd_i.emit) begin
      out_from_o   <= best_from_q;
      out_to_o     <= best_to_q;
      out_weight_o <= best_w_ext[PortWeightW-1:0];
      out_total_o  <= total_q;
      out_flag_o   <= 1'b1;
      out_last_o   <= sts_o.pass_last_removed;
    end else if (cmd_i.emit_empty) begin
      out_from_o   <= '0;
      out_to_o     <= '0;
      out_weight_o <= '0;
      out_total_o  <= '0;
      out_flag_o   <= 1'b0;
      out_last_o   <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  a_removed_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(removed_q) == removed_cnt_q)
    else $error("removed count out of step with removed marks");

  a_removed_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    removed_cnt_q <= edge_cnt_q)
    else $error("more removed edges than stored edges");

  a_emit_has_best : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit || cmd_i.mark_visited) |-> best_valid_q)
    else $error("edge used without a selected candidate");

endmodule

`default_nettype wire

/* sv/undirected_cycle_breaking_mst_unit.sv */
// ---------------------------------------------------------------------------
// undirected_cycle_breaking_mst_unit: maximum spanning forest cycle breaker
// Stores edges, builds the maximum spanning forest in descending weight
// order and reports every edge that closes a cycle, with the removed total.
// ---------------------------------------------------------------------------
// channel    dir  fields (tdata low bit up)                        tuser       tlast
// s_axis     in   edge_from[5:0] edge_to[11:6] edge_weight[27:12]  -           last_edge
// m_axis     out  removed_from[5:0] removed_to[11:6]                edge_valid  last_result
//                 removed_weight[27:12] removed_total[49:28]
// apb        in   reg 0 at address 0: node_count[6:0]
//
// edges load at one per cycle. after the last edge, each stored edge costs a
// scan of the edge store; an edge with both ends in range adds parent-store
// reads on the two root walks and a join. a prep step then starts output;
// each removed edge then costs one more scan of the edge store before it is output.
// after reset and after each run a clearing pass rewrites every entry of
// the parent store; s_axis_tready stays low then and during the whole run.
// a result waiting on m_axis_tready stalls only the next output step.
// ---------------------------------------------------------------------------
`default_nettype none

module undirected_cycle_breaking_mst_unit #(
  parameter int unsigned MAX_NODES   = ucbm_pkg::MaxNodesDef,
  parameter int unsigned MAX_EDGES   = ucbm_pkg::MaxEdgesDef,
  parameter int unsigned WEIGHT_BITS = ucbm_pkg::WeightBitsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // edge_from[5:0], edge_to[11:6], edge_weight[27:12]
  input  wire logic [ucbm_pkg::InDataW-1:0]      s_axis_tdata,
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // removed_from[5:0], removed_to[11:6], removed_weight[27:12], removed_total[49:28]
  output logic      [ucbm_pkg::OutDataW-1:0]     m_axis_tdata,
  // edge_valid[0]
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ucbm_pkg::ApbAddrW-1:0]     paddr,
  input  wire logic [ucbm_pkg::ApbDataW-1:0]     pwdata,
  output logic      [ucbm_pkg::ApbDataW-1:0]     prdata,
  output logic                                   pready
);
  import ucbm_pkg::*;

  cmd_t                    cmd;
  sts_t                    sts;
  logic [NodeCountW-1:0]   node_count_q;
  logic [IdW-1:0]          out_from;
  logic [IdW-1:0]          out_to;
  logic [PortWeightW-1:0]  out_weight;
  logic [TotalW-1:0]       out_total;
  logic                    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ApbAddrW-1] == RegNodeCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountW'(NodeCountRst);
    end else if (psel && penable && pwrite && reg_sel) begin
      node_count_q <= pwdata[NodeCountW-1:0];
    end
  end

  assign prdata = reg_sel ? ApbDataW'(node_count_q) : '0;

  ucbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ucbm_dp #(
    .MAX_NODES   (MAX_NODES),
    .MAX_EDGES   (MAX_EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .node_count_i (node_count_q),
    .in_from_i    (s_axis_tdata[IdW-1:0]),
    .in_to_i      (s_axis_tdata[2*IdW-1:IdW]),
    .in_weight_i  (s_axis_tdata[2*IdW+PortWeightW-1:2*IdW]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_from_o   (out_from),
    .out_to_o     (out_to),
    .out_weight_o (out_weight),
    .out_total_o  (out_total),
    .out_flag_o   (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = OutDataW'({out_total, out_weight, out_to, out_from});

endmodule

`default_nettype wire
